[rtl/mi3_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_pkg
// Widths, types and stage bundles shared by the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package mi3_pkg;

   localparam int DATA_WIDTH = 24;
   localparam int FRAC_BITS  = 16;
   localparam int THR_WIDTH  = DATA_WIDTH - 1;

   localparam int PROD_W = 2 * DATA_WIDTH;
   localparam int COF_W  = PROD_W + 1;
   localparam int LO_W   = DATA_WIDTH + 1;
   localparam int HI_W   = COF_W - LO_W;
   localparam int PL_W   = DATA_WIDTH + LO_W + 1;
   localparam int PH_W   = DATA_WIDTH + HI_W;
   localparam int DET_W  = DATA_WIDTH + COF_W + 2;
   localparam int THR_SH = 2 * FRAC_BITS;
   localparam int SCMP_W = (DET_W > THR_WIDTH + THR_SH) ? DET_W + 1 : THR_WIDTH + THR_SH + 1;
   localparam int NUM_SH = 2 * FRAC_BITS + 1;
   localparam int NUM_W  = COF_W + NUM_SH;
   localparam int QT_W   = DATA_WIDTH + 1;
   localparam int CMP_W  = (NUM_W > DET_W + QT_W) ? NUM_W + 1 : DET_W + QT_W + 1;
   localparam int QI_W   = $clog2(QT_W);
   localparam int STEP_W = $clog2(QT_W + 1);

   typedef logic [8:0][DATA_WIDTH-1:0] mat_type;

   typedef struct packed {
      mat_type                src;
      logic [8:0][COF_W-1:0]  adj;
   } cof_type;

   typedef struct packed {
      logic [CMP_W-1:0] rem;
      logic [QT_W-1:0]  quo;
      logic             ovf;
      logic             neg;
   } lane_type;

   typedef struct packed {
      mat_type            src;
      logic               sing;
      logic [DET_W-1:0]   dmag;
      lane_type [8:0]     lane;
   } div_type;

endpackage
`default_nettype wire

[rtl/matrix_inverse_3x3.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Pipelined 3x3 inverse by adjugate in signed Q7.16, with singular test
// and saturation.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel carries one matrix word (nine elements); rsp_ channel one
//    inverse word with singular and saturated flags. A word moves when valid
//    is high and stall is low.
//  - csr_ channel writes zero_threshold; csr_ready is always high. Write it
//    only while the pipe is empty.
//  - From acceptance to rsp_valid a word passes 2 cofactor stages,
//    5 determinant stages, 26 divider steps (an overflow check, then one
//    quotient bit per step) and the output register. One word per cycle is
//    accepted when not stalled.
//  - A singular matrix comes back unchanged with singular set.
//  - rsp_stall with a word waiting freezes the whole pipe and raises
//    req_stall in the same cycle; nothing is dropped or repeated.
//  - Reset empties the pipe and sets zero_threshold to 1.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [mi3_pkg::DATA_WIDTH-1:0]   req_in_r0_c0,
   input  logic signed [mi3_pkg::DATA_WIDTH-1:0]   req_in_r1_c0,
   input  logic signed [mi3_pkg::DATA_WIDTH-1:0]   req_in_r2_c0,
   input  logic signed [mi3_pkg::DATA_WIDTH-1:0]   req_in_r0_c1,
   input  logic signed [mi3_pkg::DATA_WIDTH-1:0]   req_in_r1_c1,
   input  logic signed [mi3_pkg::DATA_WIDTH-1:0]   req_in_r2_c1,
   input  logic signed [mi3_pkg::DATA_WIDTH-1:0]   req_in_r0_c2,
   input  logic signed [mi3_pkg::DATA_WIDTH-1:0]   req_in_r1_c2,
   input  logic signed [mi3_pkg::DATA_WIDTH-1:0]   req_in_r2_c2,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [mi3_pkg::DATA_WIDTH-1:0]   rsp_out_r0_c0,
   output logic signed [mi3_pkg::DATA_WIDTH-1:0]   rsp_out_r1_c0,
   output logic signed [mi3_pkg::DATA_WIDTH-1:0]   rsp_out_r2_c0,
   output logic signed [mi3_pkg::DATA_WIDTH-1:0]   rsp_out_r0_c1,
   output logic signed [mi3_pkg::DATA_WIDTH-1:0]   rsp_out_r1_c1,
   output logic signed [mi3_pkg::DATA_WIDTH-1:0]   rsp_out_r2_c1,
   output logic signed [mi3_pkg::DATA_WIDTH-1:0]   rsp_out_r0_c2,
   output logic signed [mi3_pkg::DATA_WIDTH-1:0]   rsp_out_r1_c2,
   output logic signed [mi3_pkg::DATA_WIDTH-1:0]   rsp_out_r2_c2,
   output logic                                    rsp_singular,
   output logic                                    rsp_saturated,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [mi3_pkg::THR_WIDTH-1:0]           csr_zero_threshold
);
   import mi3_pkg::*;

   logic                 advance;
   logic [THR_WIDTH-1:0] thr_ff;
   mat_type              req_mat;
   logic                 cof_valid;
   cof_type              cof_bus;
   logic [QT_W+1:0]      div_valid;
   div_type              div_bus [QT_W+2];

   mat_type              res_in, res_ff;
   logic                 sing_ff, sat_in, sat_ff, rsp_valid_ff;
   logic [8:0]           sat_lane;
   logic [QT_W-1:0]      qr, lim, mag;
   logic [DATA_WIDTH-1:0] sres;
   div_type              fin;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   assign req_mat = {req_in_r2_c2, req_in_r1_c2, req_in_r0_c2,
                     req_in_r2_c1, req_in_r1_c1, req_in_r0_c1,
                     req_in_r2_c0, req_in_r1_c0, req_in_r0_c0};

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_WIDTH'(1);
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_zero_threshold;
      end
   end

   mi3_cofactor u_cofactor (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_mat    (req_mat),
      .out_valid (cof_valid),
      .out_cof   (cof_bus)
   );

   mi3_det u_det (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .threshold (thr_ff),
      .in_valid  (cof_valid),
      .in_cof    (cof_bus),
      .out_valid (div_valid[0]),
      .out_div   (div_bus[0])
   );

   for (genvar s = 0; s <= QT_W; s++) begin : g_div
      mi3_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .step      (STEP_W'(QT_W - s)),
         .in_valid  (div_valid[s]),
         .in_div    (div_bus[s]),
         .out_valid (div_valid[s+1]),
         .out_div   (div_bus[s+1])
      );
   end

   // round half away from zero, saturate, apply sign
   always_comb begin
      fin      = div_bus[QT_W+1];
      sat_lane = '0;
      qr       = '0;
      lim      = '0;
      mag      = '0;
      sres     = '0;
      for (int i = 0; i < 9; i++) begin
         qr  = (fin.lane[i].quo >> 1) + QT_W'(fin.lane[i].quo[0]);
         lim = fin.lane[i].neg ? (QT_W'(1) << (DATA_WIDTH - 1))
                               : ((QT_W'(1) << (DATA_WIDTH - 1)) - QT_W'(1));
         sat_lane[i] = fin.lane[i].ovf || (qr > lim);
         mag  = sat_lane[i] ? lim : qr;
         sres = fin.lane[i].neg ? (~mag[DATA_WIDTH-1:0] + DATA_WIDTH'(1))
                                : mag[DATA_WIDTH-1:0];
         res_in[i] = fin.sing ? fin.src[i] : sres;
      end
      sat_in = !fin.sing && (|sat_lane);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid[QT_W+1];
      end
      if (advance) begin
         res_ff  <= res_in;
         sing_ff <= fin.sing;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_r0_c0 = res_ff[0];
   assign rsp_out_r1_c0 = res_ff[1];
   assign rsp_out_r2_c0 = res_ff[2];
   assign rsp_out_r0_c1 = res_ff[3];
   assign rsp_out_r1_c1 = res_ff[4];
   assign rsp_out_r2_c1 = res_ff[5];
   assign rsp_out_r0_c2 = res_ff[6];
   assign rsp_out_r1_c2 = res_ff[7];
   assign rsp_out_r2_c2 = res_ff[8];
   assign rsp_singular  = sing_ff;
   assign rsp_saturated = sat_ff;

   a_sing_no_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_singular && rsp_saturated))
      else $error("singular word flagged saturated");

   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("word presented right after reset");

   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while output is empty");

endmodule
`default_nettype wire

[rtl/mi3_cofactor.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_cofactor
// Two stages: element products, then the nine adjugate entries.
// ----------------------------------------------------------------------------
module mi3_cofactor (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  mi3_pkg::mat_type  in_mat,
   output logic              out_valid,
   output mi3_pkg::cof_type  out_cof
);
   import mi3_pkg::*;

   // adj[i] = m[IA]*m[IB] - m[IC]*m[ID], index = row + 3*column
   localparam int IA [9] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
   localparam int IB [9] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
   localparam int IC [9] = '{7, 1, 2, 3, 6, 0, 6, 0, 3};
   localparam int ID [9] = '{5, 8, 4, 8, 2, 5, 4, 7, 1};

   logic [8:0][1:0][PROD_W-1:0] prod_in, prod_ff;
   mat_type src_ff;
   logic    v1_ff, v2_ff;
   cof_type cof_in, cof_ff;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         prod_in[i][0] = PROD_W'($signed(in_mat[IA[i]])) * PROD_W'($signed(in_mat[IB[i]]));
         prod_in[i][1] = PROD_W'($signed(in_mat[IC[i]])) * PROD_W'($signed(in_mat[ID[i]]));
      end
      cof_in.src = src_ff;
      for (int i = 0; i < 9; i++) begin
         cof_in.adj[i] = COF_W'($signed(prod_ff[i][0])) - COF_W'($signed(prod_ff[i][1]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (advance) begin
         prod_ff <= prod_in;
         src_ff  <= in_mat;
         cof_ff  <= cof_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_cof   = cof_ff;

endmodule
`default_nettype wire

[rtl/mi3_det.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_det
// Determinant by first-row expansion, magnitude, singular test and divider
// lane setup. Five stages.
// ----------------------------------------------------------------------------
module mi3_det (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic [mi3_pkg::THR_WIDTH-1:0]      threshold,
   input  logic                               in_valid,
   input  mi3_pkg::cof_type                   in_cof,
   output logic                               out_valid,
   output mi3_pkg::div_type                   out_div
);
   import mi3_pkg::*;

   logic [4:0]            v_ff;
   cof_type               c3_ff, c4_ff, c5_ff, c6_ff;
   logic [2:0][PL_W-1:0]  pl_in, pl_ff;
   logic [2:0][PH_W-1:0]  ph_in, ph_ff;
   logic [2:0][DET_W-1:0] term_in, term_ff;
   logic [DET_W-1:0]      det_in, det_ff;
   logic [DET_W-1:0]      dmag_in, dmag_ff;
   logic                  dneg_ff;
   div_type               div_in, div_ff;
   logic [COF_W-1:0]      adj_mag;
   logic                  adj_neg;

   always_comb begin
      adj_mag = '0;
      adj_neg = 1'b0;
      for (int r = 0; r < 3; r++) begin
         pl_in[r] = PL_W'($signed(in_cof.src[3*r]))
                  * PL_W'($signed({1'b0, in_cof.adj[r][LO_W-1:0]}));
         ph_in[r] = PH_W'($signed(in_cof.src[3*r]))
                  * PH_W'($signed(in_cof.adj[r][COF_W-1:LO_W]));
         term_in[r] = (DET_W'($signed(ph_ff[r])) << LO_W) + DET_W'($signed(pl_ff[r]));
      end
      det_in  = term_ff[0] + term_ff[1] + term_ff[2];
      dmag_in = det_ff[DET_W-1] ? (~det_ff + DET_W'(1)) : det_ff;

      div_in.src  = c6_ff.src;
      div_in.dmag = dmag_ff;
      div_in.sing = SCMP_W'(dmag_ff) <= (SCMP_W'(threshold) << THR_SH);
      for (int i = 0; i < 9; i++) begin
         adj_neg = c6_ff.adj[i][COF_W-1];
         adj_mag = adj_neg ? (~c6_ff.adj[i] + COF_W'(1)) : c6_ff.adj[i];
         div_in.lane[i].rem = CMP_W'(adj_mag) << NUM_SH;
         div_in.lane[i].quo = '0;
         div_in.lane[i].ovf = 1'b0;
         div_in.lane[i].neg = adj_neg ^ dneg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
      if (advance) begin
         pl_ff   <= pl_in;
         ph_ff   <= ph_in;
         c3_ff   <= in_cof;
         term_ff <= term_in;
         c4_ff   <= c3_ff;
         det_ff  <= det_in;
         c5_ff   <= c4_ff;
         dmag_ff <= dmag_in;
         dneg_ff <= det_ff[DET_W-1];
         c6_ff   <= c5_ff;
         div_ff  <= div_in;
      end
   end

   assign out_valid = v_ff[4];
   assign out_div   = div_ff;

endmodule
`default_nettype wire

[rtl/mi3_div_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_div_step
// One restoring division step for all nine lanes. The top step flags
// quotient overflow, the others produce one quotient bit each.
// ----------------------------------------------------------------------------
module mi3_div_step (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [mi3_pkg::STEP_W-1:0]  step,
   input  logic                        in_valid,
   input  mi3_pkg::div_type            in_div,
   output logic                        out_valid,
   output mi3_pkg::div_type            out_div
);
   import mi3_pkg::*;

   logic             valid_ff;
   div_type          div_in, div_ff;
   logic [CMP_W-1:0] shifted;

   always_comb begin
      div_in  = in_div;
      shifted = CMP_W'(in_div.dmag) << step;
      for (int i = 0; i < 9; i++) begin
         if (in_div.lane[i].rem >= shifted) begin
            div_in.lane[i].rem = in_div.lane[i].rem - shifted;
            if (step == STEP_W'(QT_W)) begin
               div_in.lane[i].ovf = 1'b1;
            end else begin
               div_in.lane[i].quo[step[QI_W-1:0]] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         div_ff <= div_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for matrix_inverse_3x3: random and directed matrices
// under varied handshake idling, predicted inverse compared per field.
// ----------------------------------------------------------------------------
module tb_top;
   import mi3_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int LATENCY = 34;
   localparam int WATCHDOG = 20000;

   typedef logic signed [DW-1:0] elem_t;

   typedef struct {
      elem_t m[9];
   } matrix_t;

   typedef struct {
      elem_t m[9];
      logic  singular;
      logic  saturated;
   } inverse_t;

   // exact predictor of the pipeline
   function automatic inverse_t invert_matrix(matrix_t a, logic [THR_WIDTH-1:0] thr);
      inverse_t r;
      logic signed [127:0] e[9];
      logic signed [127:0] adj[9];
      logic signed [127:0] det, dmag, num, q, rm, lim, v, plim;
      logic dneg, neg;
      for (int i = 0; i < 9; i++) e[i] = a.m[i];
      adj[0] = e[4] * e[8] - e[7] * e[5];
      adj[1] = e[7] * e[2] - e[1] * e[8];
      adj[2] = e[1] * e[5] - e[2] * e[4];
      adj[3] = e[6] * e[5] - e[3] * e[8];
      adj[4] = e[0] * e[8] - e[6] * e[2];
      adj[5] = e[3] * e[2] - e[0] * e[5];
      adj[6] = e[3] * e[7] - e[6] * e[4];
      adj[7] = e[6] * e[1] - e[0] * e[7];
      adj[8] = e[0] * e[4] - e[3] * e[1];
      det = e[0] * adj[0] + e[3] * adj[1] + e[6] * adj[2];
      dneg = det < 0;
      dmag = dneg ? -det : det;
      plim = (128'sd1 <<< (DW - 1)) - 1;
      r.saturated = 0;
      if (dmag <= ($signed({105'd0, thr}) <<< (2 * FRAC_BITS))) begin
         r.m = a.m;
         r.singular = 1;
         return r;
      end
      r.singular = 0;
      for (int i = 0; i < 9; i++) begin
         neg = (adj[i] < 0) != dneg;
         lim = neg ? plim + 1 : plim;
         num = (adj[i] < 0 ? -adj[i] : adj[i]) <<< (2 * FRAC_BITS);
         q = num / dmag;
         rm = num % dmag;
         if (2 * rm >= dmag) q = q + 1;
         if (q > lim) begin
            v = lim;
            r.saturated = 1;
         end else begin
            v = q;
         end
         r.m[i] = elem_t'(neg ? -v : v);
      end
      return r;
   endfunction

   class inverse_board;
      inverse_t pending[$];
      int errors = 0;

      function void note_matrix(inverse_t x);
         pending.push_back(x);
      endfunction

      function void check_inverse(inverse_t got);
         inverse_t x;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word", $time);
            errors++;
            return;
         end
         x = pending.pop_front();
         for (int i = 0; i < 9; i++)
            if (got.m[i] !== x.m[i]) begin
               $display("%0t: element %0d expected %0d actual %0d",
                        $time, i, x.m[i], got.m[i]);
               errors++;
            end
         if (got.singular !== x.singular) begin
            $display("%0t: singular expected %0b actual %0b",
                     $time, x.singular, got.singular);
            errors++;
         end
         if (got.saturated !== x.saturated) begin
            $display("%0t: saturated expected %0b actual %0b",
                     $time, x.saturated, got.saturated);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall;
   elem_t req_el[9];
   logic rsp_valid, rsp_stall = 0;
   elem_t rsp_el[9];
   logic rsp_singular, rsp_saturated;
   logic csr_valid = 0, csr_ready;
   logic [THR_WIDTH-1:0] csr_zero_threshold = 0;

   logic [THR_WIDTH-1:0] threshold = 1;
   int send_idle = 0, recv_stall = 0;
   bit hold_off = 0;
   int quiet = 0;
   inverse_board board = new();

   initial for (int i = 0; i < 9; i++) req_el[i] = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   matrix_inverse_3x3 uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_in_r0_c0(req_el[0]), .req_in_r1_c0(req_el[1]), .req_in_r2_c0(req_el[2]),
      .req_in_r0_c1(req_el[3]), .req_in_r1_c1(req_el[4]), .req_in_r2_c1(req_el[5]),
      .req_in_r0_c2(req_el[6]), .req_in_r1_c2(req_el[7]), .req_in_r2_c2(req_el[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_r0_c0(rsp_el[0]), .rsp_out_r1_c0(rsp_el[1]), .rsp_out_r2_c0(rsp_el[2]),
      .rsp_out_r0_c1(rsp_el[3]), .rsp_out_r1_c1(rsp_el[4]), .rsp_out_r2_c1(rsp_el[5]),
      .rsp_out_r0_c2(rsp_el[6]), .rsp_out_r1_c2(rsp_el[7]), .rsp_out_r2_c2(rsp_el[8]),
      .rsp_singular(rsp_singular), .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_zero_threshold(csr_zero_threshold)
   );

   // result side: stall pattern, checks, watchdog
   always @(posedge clock) begin
      inverse_t got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.m = rsp_el;
            got.singular = rsp_singular;
            got.saturated = rsp_saturated;
            board.check_inverse(got);
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || csr_valid)
            quiet <= 0;
         else
            quiet <= quiet + 1;
         if (quiet > WATCHDOG) begin
            $display("FAILURE");
            $finish;
         end
         rsp_stall <= hold_off || ($urandom_range(99) < recv_stall);
      end
   end

   task automatic write_threshold(logic [THR_WIDTH-1:0] v);
      csr_valid <= 1;
      csr_zero_threshold <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      threshold = v;
   endtask

   // valid stays high from one word to the next when there is no idle gap
   task automatic send_matrix(matrix_t a);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_el <= a.m;
      do @(posedge clock); while (req_stall);
      board.note_matrix(invert_matrix(a, threshold));
   endtask

   task automatic drain;
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic elem_t rand_elem(int mode);
      case (mode)
         0: return elem_t'($urandom);
         1: return elem_t'($signed($urandom_range(2 ** 18)) - (2 ** 17));
         2: return elem_t'($signed($urandom_range(2 ** 12)) - (2 ** 11));
         default: return $urandom_range(1) ? elem_t'(1 << FRAC_BITS) : elem_t'(0);
      endcase
   endfunction

   function automatic matrix_t rand_matrix();
      matrix_t a;
      int mode = $urandom_range(5);
      for (int i = 0; i < 9; i++) a.m[i] = rand_elem(mode > 3 ? 1 : mode);
      if (mode == 5) begin
         // rank deficient: third column copies the first
         a.m[6] = a.m[0]; a.m[7] = a.m[1]; a.m[8] = a.m[2];
      end
      if ($urandom_range(9) == 0) a.m[$urandom_range(8)] = rand_elem(3);
      return a;
   endfunction

   function automatic matrix_t diag(elem_t d0, elem_t d1, elem_t d2);
      matrix_t a;
      for (int i = 0; i < 9; i++) a.m[i] = 0;
      a.m[0] = d0; a.m[4] = d1; a.m[8] = d2;
      return a;
   endfunction

   initial begin
      matrix_t a;
      elem_t one = elem_t'(1 << FRAC_BITS);
      elem_t maxv = elem_t'({1'b0, {(DW-1){1'b1}}});
      elem_t minv = elem_t'({1'b1, {(DW-1){1'b0}}});
      int phase_len;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed
      send_matrix(diag(one, one, one));
      send_matrix(diag(maxv, maxv, maxv));
      send_matrix(diag(minv, minv, minv));
      send_matrix(diag(minv, maxv, minv));
      send_matrix(diag(1, 1, 1));
      send_matrix(diag(-1, 2, 3));
      send_matrix(diag(0, one, one));
      send_matrix(diag(one >>> 1, -one, one <<< 2));
      for (int i = 0; i < 9; i++) a.m[i] = maxv;
      send_matrix(a);
      for (int i = 0; i < 9; i++) a.m[i] = (i % 2) ? minv : maxv;
      send_matrix(a);
      for (int i = 0; i < 9; i++) a.m[i] = elem_t'(i * one + (i == 0 ? one : 0));
      send_matrix(a);
      a = diag(one, one, one);
      a.m[3] = -(one <<< 3); a.m[7] = one <<< 4; a.m[2] = -one;
      send_matrix(a);
      send_matrix(diag(one, one, 2));
      drain();
      write_threshold(THR_WIDTH'(0));
      send_matrix(diag(0, 0, 0));
      send_matrix(diag(1, 1, 1));
      send_matrix(diag(minv, one, one));
      drain();
      write_threshold({THR_WIDTH{1'b1}});
      send_matrix(diag(maxv, maxv, maxv));
      send_matrix(diag(one, one, one));
      send_matrix(diag(maxv, maxv, 1));
      drain();

      // random phases
      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 50; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 50; end
            default: begin send_idle = 6; recv_stall = 6; end
         endcase
         case (p)
            0: write_threshold(THR_WIDTH'(1));
            1: write_threshold(THR_WIDTH'(0));
            2: write_threshold(THR_WIDTH'($urandom_range(2 ** 8)));
            3: write_threshold(THR_WIDTH'($urandom_range({THR_WIDTH{1'b1}})));
            4: write_threshold({THR_WIDTH{1'b1}});
            default: write_threshold(THR_WIDTH'($urandom_range(16)));
         endcase
         phase_len = 240;
         if (p == 0) begin
            // long receiver hold-off while the sender keeps going
            fork
               begin
                  hold_off = 1;
                  repeat (200) @(posedge clock);
                  hold_off = 0;
               end
            join_none
         end
         repeat (phase_len) send_matrix(rand_matrix());
         drain();
      end

      if (board.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule

[files.f]
rtl/mi3_pkg.sv
rtl/mi3_cofactor.sv
rtl/mi3_det.sv
rtl/mi3_div_step.sv
rtl/matrix_inverse_3x3.sv
tb/tb_top.sv
